/* design/acl_pkg.sv */
// Package for the five-tuple ACL classifier: types, codes and sizes.
// No dependencies; used by every module of the block.
package acl_pkg;

    localparam int RulesPerChain = 64;
    localparam int IdxW = $clog2(RulesPerChain);
    localparam int CntW = $clog2(RulesPerChain + 1);
    localparam int AddrW = IdxW + 1;

    localparam logic [7:0] ProtoTcp = 8'd6;
    localparam logic [7:0] ProtoUdp = 8'd17;

    localparam logic [1:0] ModeClassify = 2'd0;
    localparam logic [1:0] ModeAdd = 2'd1;
    localparam logic [1:0] ModeDelete = 2'd2;
    localparam logic [1:0] ModeUnused = 2'd3;

    localparam logic [1:0] PolicyAccept = 2'd0;
    localparam logic [1:0] PolicyDrop = 2'd1;
    localparam logic [1:0] PolicyNone = 2'd2;

    localparam logic [1:0] StatOk = 2'd0;
    localparam logic [1:0] StatFull = 2'd1;
    localparam logic [1:0] StatNotFound = 2'd2;

    localparam logic [1:0] CfgEnable = 2'd0;
    localparam logic [1:0] CfgInDefault = 2'd1;
    localparam logic [1:0] CfgOutDefault = 2'd2;

    typedef struct packed {
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  protocol;
        logic [1:0]  policy;
        logic        disabled;
    } t_rule;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic rd;
        logic wr_item;
        logic wr_shift;
        logic idx_clr;
        logic idx_inc;
        logic cnt_inc;
        logic cnt_dec;
        logic set_result;
        logic res_hit;
        logic res_found;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       idx_end;
        logic       shift_end;
        logic       full;
        logic       match;
        logic       key_eq;
    } t_stat;

endpackage

/* design/acl_datapath.sv */
// Datapath of the ACL classifier: item register, rule memory, counts, compare.
// Depends on acl_pkg.
module acl_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  acl_pkg::t_cmd     i_cmd,
    output acl_pkg::t_stat    o_stat,
    input  logic [1:0]        i_mode,
    input  logic              i_chain,
    input  acl_pkg::t_rule    i_item,
    input  logic              i_filter_enable,
    input  logic              i_in_default,
    input  logic              i_out_default,
    output logic              o_verdict,
    output logic              o_rule_hit,
    output logic              o_log_request,
    output logic [1:0]        o_status
);

    acl_pkg::t_rule r_mem [2*acl_pkg::RulesPerChain];
    acl_pkg::t_rule r_rd;
    acl_pkg::t_rule r_item;
    logic [1:0] r_mode;
    logic r_chain;
    logic [acl_pkg::CntW-1:0] r_cnt [2];
    logic [acl_pkg::CntW-1:0] r_idx;
    logic r_verdict, r_hit, r_log;
    logic [1:0] r_status;
    logic [acl_pkg::CntW-1:0] cnt;
    logic [acl_pkg::AddrW-1:0] rd_addr, wr_addr;
    logic [acl_pkg::CntW-1:0] nxt, nxt2;
    logic classify_ok, match;

    assign cnt = r_cnt[r_chain];
    assign nxt = r_idx + 1'b1;
    assign nxt2 = r_idx + 2'd2;
    // shift reads fetch idx+1, or idx+2 when idx advances, one entry ahead of the next write
    assign rd_addr = {r_chain, !i_cmd.wr_shift ? r_idx[acl_pkg::IdxW-1:0] :
                               i_cmd.idx_inc   ? nxt2[acl_pkg::IdxW-1:0]
                                               : nxt[acl_pkg::IdxW-1:0]};
    assign wr_addr = i_cmd.wr_item ? {r_chain, cnt[acl_pkg::IdxW-1:0]}
                                   : {r_chain, r_idx[acl_pkg::IdxW-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd <= r_mem[rd_addr];
        end
        if (i_cmd.wr_item) begin
            r_mem[wr_addr] <= r_item;
        end else if (i_cmd.wr_shift) begin
            r_mem[wr_addr] <= r_rd;
        end
    end

    assign classify_ok = i_filter_enable &&
        (r_item.protocol == acl_pkg::ProtoTcp || r_item.protocol == acl_pkg::ProtoUdp);
    assign match = !r_rd.disabled && r_rd.protocol == r_item.protocol &&
        (r_rd.sport == 16'd0 || r_rd.sport == r_item.sport) &&
        (r_rd.dport == 16'd0 || r_rd.dport == r_item.dport) &&
        (r_rd.saddr == 32'd0 || r_rd.saddr == r_item.saddr) &&
        (r_rd.daddr == 32'd0 || r_rd.daddr == r_item.daddr);

    assign o_stat.mode = r_mode;
    assign o_stat.idx_end = r_idx >= cnt || (r_mode == acl_pkg::ModeClassify && !classify_ok);
    assign o_stat.shift_end = nxt >= cnt;
    assign o_stat.full = cnt >= acl_pkg::CntW'(acl_pkg::RulesPerChain);
    assign o_stat.match = match;
    assign o_stat.key_eq = r_rd.saddr == r_item.saddr &&
        r_rd.daddr == r_item.daddr && r_rd.sport == r_item.sport &&
        r_rd.dport == r_item.dport && r_rd.protocol == r_item.protocol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
            r_idx <= '0;
        end else begin
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= nxt;
            end
            if (i_cmd.cnt_inc) begin
                r_cnt[r_chain] <= cnt + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_cnt[r_chain] <= cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_chain <= i_chain;
            r_item <= i_item;
        end
        if (i_cmd.set_result) begin
            r_verdict <= 1'b0;
            r_hit <= 1'b0;
            r_log <= 1'b0;
            r_status <= acl_pkg::StatOk;
            case (r_mode)
                acl_pkg::ModeClassify: begin
                    if (i_cmd.res_hit) begin
                        r_verdict <= r_rd.policy != acl_pkg::PolicyAccept;
                        r_hit <= 1'b1;
                        r_log <= r_item.protocol == acl_pkg::ProtoUdp;
                    end else if (classify_ok) begin
                        r_verdict <= r_chain ? i_out_default : i_in_default;
                    end
                end
                acl_pkg::ModeAdd: begin
                    if (o_stat.full) r_status <= acl_pkg::StatFull;
                end
                acl_pkg::ModeDelete: begin
                    if (!i_cmd.res_found) r_status <= acl_pkg::StatNotFound;
                end
                default: ;
            endcase
        end
    end

    assign o_verdict = r_verdict;
    assign o_rule_hit = r_hit;
    assign o_log_request = r_log;
    assign o_status = r_status;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] <= acl_pkg::CntW'(acl_pkg::RulesPerChain) &&
        r_cnt[1] <= acl_pkg::CntW'(acl_pkg::RulesPerChain)) else $error("count overflow");
    a_no_add_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |-> !o_stat.full) else $error("add to full chain");
    a_dec_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_dec |-> cnt != '0) else $error("delete from empty chain");

endmodule

/* design/acl_ctrl.sv */
// Controller of the ACL classifier: scans, adds and deletes rules.
// Depends on acl_pkg.
module acl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  acl_pkg::t_stat  i_stat,
    output acl_pkg::t_cmd   o_cmd
);

    acl_pkg::t_state r_state, n_state;
    logic r_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            acl_pkg::ST_IDLE: begin
                if (i_in_valid && !(r_valid && i_out_stall)) n_state = acl_pkg::ST_READ;
            end
            acl_pkg::ST_READ: begin
                if (i_stat.mode == acl_pkg::ModeClassify ||
                    i_stat.mode == acl_pkg::ModeDelete) begin
                    n_state = i_stat.idx_end ? acl_pkg::ST_DONE : acl_pkg::ST_CHECK;
                end else begin
                    n_state = acl_pkg::ST_DONE;
                end
            end
            acl_pkg::ST_CHECK: begin
                if (i_stat.mode == acl_pkg::ModeClassify) begin
                    n_state = i_stat.match ? acl_pkg::ST_DONE : acl_pkg::ST_READ;
                end else if (i_stat.key_eq) begin
                    n_state = i_stat.shift_end ? acl_pkg::ST_DONE : acl_pkg::ST_SHIFT_WR;
                end else begin
                    n_state = acl_pkg::ST_READ;
                end
            end
            acl_pkg::ST_SHIFT_WR: begin
                n_state = i_stat.shift_end ? acl_pkg::ST_DONE : acl_pkg::ST_SHIFT_WR;
            end
            acl_pkg::ST_SHIFT_RD: n_state = acl_pkg::ST_DONE;
            acl_pkg::ST_DONE: n_state = acl_pkg::ST_IDLE;
            default: n_state = acl_pkg::ST_IDLE;
        endcase
    end

    // Delete: on key match, each SHIFT_WR cycle writes r_rd (entry idx+1) to idx.
    // The read of idx+1 is issued alongside, so CHECK and SHIFT_WR pre-read it.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            acl_pkg::ST_IDLE: begin
                o_cmd.load = i_in_valid && !(r_valid && i_out_stall);
                o_cmd.idx_clr = 1'b1;
            end
            acl_pkg::ST_READ: begin
                o_cmd.rd = 1'b1;
                if (i_stat.mode == acl_pkg::ModeAdd) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.wr_item = !i_stat.full;
                    o_cmd.cnt_inc = !i_stat.full;
                end else if (i_stat.idx_end || (i_stat.mode != acl_pkg::ModeClassify &&
                                               i_stat.mode != acl_pkg::ModeDelete)) begin
                    o_cmd.set_result = 1'b1;
                end
            end
            acl_pkg::ST_CHECK: begin
                if (i_stat.mode == acl_pkg::ModeClassify) begin
                    o_cmd.idx_inc = !i_stat.match;
                    o_cmd.set_result = i_stat.match;
                    o_cmd.res_hit = i_stat.match;
                end else if (i_stat.key_eq) begin
                    o_cmd.rd = 1'b1;
                    o_cmd.wr_shift = 1'b1;
                    o_cmd.set_result = i_stat.shift_end;
                    o_cmd.res_found = 1'b1;
                    o_cmd.cnt_dec = i_stat.shift_end;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            acl_pkg::ST_SHIFT_WR: begin
                o_cmd.idx_inc = 1'b1;
                o_cmd.rd = 1'b1;
                o_cmd.wr_shift = 1'b1;
                o_cmd.set_result = i_stat.shift_end;
                o_cmd.res_found = 1'b1;
                o_cmd.cnt_dec = i_stat.shift_end;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acl_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == acl_pkg::ST_DONE) begin
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall = r_state != acl_pkg::ST_IDLE || (r_valid && i_out_stall);
    assign o_out_valid = r_valid;

    a_one_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == acl_pkg::ST_DONE |-> !r_valid || !i_out_stall) else $error("result overrun");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != acl_pkg::ST_IDLE |-> o_in_stall) else $error("accept while busy");
    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.wr_item && o_cmd.wr_shift)) else $error("double write");

endmodule

/* design/five_tuple_acl_classifier_top.sv */
// Top level of the five-tuple ACL classifier: config registers, controller, datapath.
// Depends on acl_pkg, acl_ctrl and acl_datapath.
//
// Input channel (i_in_valid / o_in_stall) takes one item: classify, add or delete
// a rule in the input or output chain. Output channel (o_out_valid / i_out_stall)
// returns one result per item. Configuration is a valid/ready write port with
// register index and data; it is always ready and should be written while idle.
// After the accepting edge the controller passes READ and DONE for add, for
// mode 3 and for a packet that skips matching; otherwise it reads each rule in
// READ and compares it in CHECK, ending the scan at the chain's end or on a hit,
// and on delete moves each later rule up one entry in SHIFT_WR. The rule memory
// has one read and one write port. o_out_valid rises after DONE.
// One item is in work at a time; the next can be taken as soon as o_out_valid
// rises, in the same cycle the result leaves. While the output is stalled with a
// result pending, no new item is taken. Reset clears both rule counts, enables
// the filter and sets both default policies to accept. The rule memory needs
// no clearing since only entries below a chain's count are used.
module five_tuple_acl_classifier_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic        i_chain,
    input  logic [7:0]  i_protocol,
    input  logic [15:0] i_sport,
    input  logic [15:0] i_dport,
    input  logic [31:0] i_saddr,
    input  logic [31:0] i_daddr,
    input  logic [1:0]  i_rule_policy,
    input  logic        i_rule_disabled,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_verdict,
    output logic        o_rule_hit,
    output logic        o_log_request,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data
);

    logic r_enable, r_in_def, r_out_def;
    acl_pkg::t_cmd cmd;
    acl_pkg::t_stat stat;
    acl_pkg::t_rule item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_in_def <= 1'b0;
            r_out_def <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                acl_pkg::CfgEnable: r_enable <= i_cfg_data;
                acl_pkg::CfgInDefault: r_in_def <= i_cfg_data;
                acl_pkg::CfgOutDefault: r_out_def <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign item = '{saddr: i_saddr, daddr: i_daddr, sport: i_sport,
                    dport: i_dport, protocol: i_protocol, policy: i_rule_policy,
                    disabled: i_rule_disabled};

    acl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_stat(stat), .o_cmd(cmd)
    );

    acl_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_stat(stat),
        .i_mode(i_mode), .i_chain(i_chain), .i_item(item),
        .i_filter_enable(r_enable), .i_in_default(r_in_def), .i_out_default(r_out_def),
        .o_verdict(o_verdict), .o_rule_hit(o_rule_hit),
        .o_log_request(o_log_request), .o_status(o_status)
    );

endmodule

/* sim/acl_checker.sv */
// Checker for the five-tuple ACL classifier: watches the item, result and
// config channels, predicts each result and compares. Depends on acl_pkg.
module acl_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_mode,
    input  logic        i_chain,
    input  logic [7:0]  i_protocol,
    input  logic [15:0] i_sport,
    input  logic [15:0] i_dport,
    input  logic [31:0] i_saddr,
    input  logic [31:0] i_daddr,
    input  logic [1:0]  i_rule_policy,
    input  logic        i_rule_disabled,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_verdict,
    input  logic        i_rule_hit,
    input  logic        i_log_request,
    input  logic [1:0]  i_status,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       verdict;
        logic       rule_hit;
        logic       log_request;
        logic [1:0] status;
    } t_verdict;

    acl_pkg::t_rule acl_rules[2][acl_pkg::RulesPerChain];
    int       chain_len[2];
    logic     flt_en, in_dflt, out_dflt;
    t_verdict verdict_q[$];
    int       fails;

    assign o_fail_count = fails;
    assign o_pending = verdict_q.size();

    function automatic logic field_ok(logic [31:0] r, logic [31:0] p);
        return r == 32'd0 || r == p;
    endfunction

    task automatic apply_item(acl_pkg::t_rule it, logic [1:0] mode, logic ch);
        t_verdict v;
        int n;
        acl_pkg::t_rule r;
        v = '0;
        n = chain_len[ch];
        if (mode == acl_pkg::ModeClassify) begin
            if (flt_en && (it.protocol == acl_pkg::ProtoTcp ||
                           it.protocol == acl_pkg::ProtoUdp)) begin
                v.verdict = ch ? out_dflt : in_dflt;
                for (int i = 0; i < n; i++) begin
                    r = acl_rules[ch][i];
                    if (!r.disabled && r.protocol == it.protocol &&
                        field_ok(32'(r.sport), 32'(it.sport)) &&
                        field_ok(32'(r.dport), 32'(it.dport)) &&
                        field_ok(r.saddr, it.saddr) &&
                        field_ok(r.daddr, it.daddr)) begin
                        v.verdict = r.policy != acl_pkg::PolicyAccept;
                        v.rule_hit = 1'b1;
                        v.log_request = it.protocol == acl_pkg::ProtoUdp;
                        break;
                    end
                end
            end
        end else if (mode == acl_pkg::ModeAdd) begin
            if (n >= acl_pkg::RulesPerChain) begin
                v.status = acl_pkg::StatFull;
            end else begin
                acl_rules[ch][n] = it;
                chain_len[ch] = n + 1;
            end
        end else if (mode == acl_pkg::ModeDelete) begin
            v.status = acl_pkg::StatNotFound;
            for (int i = 0; i < n; i++) begin
                r = acl_rules[ch][i];
                if (r.saddr == it.saddr && r.daddr == it.daddr &&
                    r.sport == it.sport && r.dport == it.dport &&
                    r.protocol == it.protocol) begin
                    for (int j = i; j < n - 1; j++) acl_rules[ch][j] = acl_rules[ch][j + 1];
                    chain_len[ch] = n - 1;
                    v.status = acl_pkg::StatOk;
                    break;
                end
            end
        end
        verdict_q.push_back(v);
    endtask

    always @(posedge i_clk) begin
        acl_pkg::t_rule it;
        t_verdict e;
        if (!i_rst_n) begin
            chain_len[0] = 0;
            chain_len[1] = 0;
            flt_en = 1'b1;
            in_dflt = 1'b0;
            out_dflt = 1'b0;
            verdict_q.delete();
            fails = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    $error("unexpected result item");
                    fails++;
                end else begin
                    e = verdict_q.pop_front();
                    if (i_verdict !== e.verdict) begin
                        $error("verdict exp %0d got %0d", e.verdict, i_verdict);
                        fails++;
                    end
                    if (i_rule_hit !== e.rule_hit) begin
                        $error("rule_hit exp %0d got %0d", e.rule_hit, i_rule_hit);
                        fails++;
                    end
                    if (i_log_request !== e.log_request) begin
                        $error("log_request exp %0d got %0d", e.log_request, i_log_request);
                        fails++;
                    end
                    if (i_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, i_status);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    acl_pkg::CfgEnable: flt_en = i_cfg_data;
                    acl_pkg::CfgInDefault: in_dflt = i_cfg_data;
                    acl_pkg::CfgOutDefault: out_dflt = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                it.saddr = i_saddr;
                it.daddr = i_daddr;
                it.sport = i_sport;
                it.dport = i_dport;
                it.protocol = i_protocol;
                it.policy = i_rule_policy;
                it.disabled = i_rule_disabled;
                apply_item(it, i_mode, i_chain);
            end
        end
    end
endmodule

/* sim/five_tuple_acl_classifier_top_tb.sv */
// Testbench top for the five-tuple ACL classifier: clock, reset, stimulus and
// verdict. Depends on acl_pkg, five_tuple_acl_classifier_top and acl_checker.
module five_tuple_acl_classifier_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 2000000;

    logic        clk, rst_n;
    logic        in_valid, in_stall;
    logic [1:0]  mode;
    logic        chain;
    logic [7:0]  protocol;
    logic [15:0] sport, dport;
    logic [31:0] saddr, daddr;
    logic [1:0]  rule_policy;
    logic        rule_disabled;
    logic        out_valid, out_stall;
    logic        verdict, rule_hit, log_request;
    logic [1:0]  status;
    logic        cfg_valid, cfg_ready;
    logic [1:0]  cfg_index;
    logic        cfg_data;
    int          fail_count, pending;
    int          cycles;
    int          stall_mode;

    // pool of tuples so classify and delete hit stored rules often
    logic [7:0]  pool_proto[8];
    logic [15:0] pool_sp[8], pool_dp[8];
    logic [31:0] pool_sa[8], pool_da[8];

    five_tuple_acl_classifier_top i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_mode(mode), .i_chain(chain), .i_protocol(protocol),
        .i_sport(sport), .i_dport(dport),
        .i_saddr(saddr), .i_daddr(daddr),
        .i_rule_policy(rule_policy), .i_rule_disabled(rule_disabled),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_verdict(verdict), .o_rule_hit(rule_hit),
        .o_log_request(log_request), .o_status(status),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    acl_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_mode(mode), .i_chain(chain), .i_protocol(protocol),
        .i_sport(sport), .i_dport(dport),
        .i_saddr(saddr), .i_daddr(daddr),
        .i_rule_policy(rule_policy), .i_rule_disabled(rule_disabled),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_verdict(verdict), .i_rule_hit(rule_hit),
        .i_log_request(log_request), .i_status(status),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver stall pattern: phases of none, light, heavy, periodic
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= $urandom_range(0, 3) == 0;
                2: out_stall <= $urandom_range(0, 3) != 0;
                default: out_stall <= cycles[2];
            endcase
        end
    end

    task automatic send_item(logic [1:0] m, logic ch, logic [7:0] p, logic [15:0] sp,
                             logic [15:0] dp, logic [31:0] sa, logic [31:0] da,
                             logic [1:0] pol, logic dis);
        mode <= m;
        chain <= ch;
        protocol <= p;
        sport <= sp;
        dport <= dp;
        saddr <= sa;
        daddr <= da;
        rule_policy <= pol;
        rule_disabled <= dis;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic idle_gap(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic d);
        cfg_index <= idx;
        cfg_data <= d;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_item();
        int k, sel;
        logic [1:0] m;
        logic [7:0] p;
        logic [15:0] sp, dp;
        logic [31:0] sa, da;
        k = $urandom_range(0, 7);
        sel = $urandom_range(0, 99);
        m = sel < 50 ? acl_pkg::ModeClassify :
            (sel < 80 ? acl_pkg::ModeAdd :
             (sel < 97 ? acl_pkg::ModeDelete : acl_pkg::ModeUnused));
        p = pool_proto[k];
        sp = pool_sp[k];
        dp = pool_dp[k];
        sa = pool_sa[k];
        da = pool_da[k];
        if (m == acl_pkg::ModeAdd) begin
            // wildcards in rules
            if ($urandom_range(0, 2) == 0) sp = '0;
            if ($urandom_range(0, 2) == 0) dp = '0;
            if ($urandom_range(0, 2) == 0) sa = '0;
            if ($urandom_range(0, 2) == 0) da = '0;
        end
        if ($urandom_range(0, 9) == 0) begin
            p = 8'($urandom);
            sp = 16'($urandom);
            dp = 16'($urandom);
            sa = $urandom;
            da = $urandom;
        end
        send_item(m, 1'($urandom_range(0, 1)), p, sp, dp, sa, da,
                  2'($urandom_range(0, 3)), $urandom_range(0, 5) == 0);
    endtask

    initial begin
        int sent, burst;
        cycles = 0;
        stall_mode = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = '0; chain = 1'b0; protocol = '0; sport = '0; dport = '0;
        saddr = '0; daddr = '0; rule_policy = '0; rule_disabled = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_item(acl_pkg::ModeClassify, 1'b0, acl_pkg::ProtoTcp, 16'hFFFF, 16'h0001,
                  32'hFFFFFFFF, 32'h0, acl_pkg::PolicyAccept, 1'b0);
        send_item(acl_pkg::ModeAdd, 1'b0, acl_pkg::ProtoTcp, 16'd80, 16'd0, 32'h0,
                  32'h0A000001, acl_pkg::PolicyDrop, 1'b0);
        send_item(acl_pkg::ModeAdd, 1'b0, acl_pkg::ProtoUdp, 16'd0, 16'd53, 32'h0, 32'h0,
                  acl_pkg::PolicyAccept, 1'b0);
        send_item(acl_pkg::ModeAdd, 1'b0, acl_pkg::ProtoUdp, 16'd0, 16'd0, 32'h0, 32'h0,
                  acl_pkg::PolicyNone, 1'b0);
        send_item(acl_pkg::ModeAdd, 1'b1, 8'd1, 16'd0, 16'd0, 32'h0, 32'h0,
                  acl_pkg::PolicyDrop, 1'b0);
        send_item(acl_pkg::ModeAdd, 1'b1, acl_pkg::ProtoTcp, 16'hFFFF, 16'hFFFF,
                  32'hFFFFFFFF, 32'hFFFFFFFF, 2'd3, 1'b0);
        send_item(acl_pkg::ModeAdd, 1'b1, acl_pkg::ProtoTcp, 16'd0, 16'd0, 32'h0, 32'h0,
                  acl_pkg::PolicyDrop, 1'b1);
        send_item(acl_pkg::ModeClassify, 1'b0, acl_pkg::ProtoTcp, 16'd80, 16'd7, 32'h1,
                  32'h0A000001, acl_pkg::PolicyAccept, 1'b0);
        send_item(acl_pkg::ModeClassify, 1'b0, acl_pkg::ProtoTcp, 16'd80, 16'd7, 32'h1,
                  32'h0A000002, acl_pkg::PolicyAccept, 1'b0);
        send_item(acl_pkg::ModeClassify, 1'b0, acl_pkg::ProtoUdp, 16'd9, 16'd53, 32'h5,
                  32'h6, acl_pkg::PolicyAccept, 1'b0);
        send_item(acl_pkg::ModeClassify, 1'b0, acl_pkg::ProtoUdp, 16'd9, 16'd54, 32'h5,
                  32'h6, acl_pkg::PolicyAccept, 1'b0);
        send_item(acl_pkg::ModeClassify, 1'b1, 8'd1, 16'd0, 16'd0, 32'h0, 32'h0,
                  acl_pkg::PolicyAccept, 1'b0);
        send_item(acl_pkg::ModeClassify, 1'b1, acl_pkg::ProtoTcp, 16'hFFFF, 16'hFFFF,
                  32'hFFFFFFFF, 32'hFFFFFFFF, 2'd3, 1'b1);
        send_item(acl_pkg::ModeClassify, 1'b1, 8'hFF, 16'h0, 16'h0, 32'h0, 32'h0,
                  acl_pkg::PolicyAccept, 1'b0);
        send_item(acl_pkg::ModeDelete, 1'b0, acl_pkg::ProtoUdp, 16'd0, 16'd53, 32'h0,
                  32'h0, 2'd3, 1'b1);
        send_item(acl_pkg::ModeDelete, 1'b0, acl_pkg::ProtoUdp, 16'd0, 16'd53, 32'h0,
                  32'h0, acl_pkg::PolicyAccept, 1'b0);
        send_item(acl_pkg::ModeClassify, 1'b0, acl_pkg::ProtoUdp, 16'd9, 16'd53, 32'h5,
                  32'h6, acl_pkg::PolicyAccept, 1'b0);
        send_item(acl_pkg::ModeUnused, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF,
                  32'hFFFFFFFF, 2'd3, 1'b1);
        // fill output chain to full
        for (int i = 0; i < acl_pkg::RulesPerChain; i++)
            send_item(acl_pkg::ModeAdd, 1'b1, acl_pkg::ProtoUdp, i[15:0] + 16'd100, 16'd0,
                      32'h0, 32'h0, acl_pkg::PolicyAccept, 1'b0);
        send_item(acl_pkg::ModeClassify, 1'b1, acl_pkg::ProtoUdp, 16'd163, 16'd1, 32'h1,
                  32'h1, acl_pkg::PolicyAccept, 1'b0);
        send_item(acl_pkg::ModeDelete, 1'b1, acl_pkg::ProtoTcp, 16'hFFFF, 16'hFFFF,
                  32'hFFFFFFFF, 32'hFFFFFFFF, acl_pkg::PolicyAccept, 1'b0);
        send_item(acl_pkg::ModeAdd, 1'b1, acl_pkg::ProtoUdp, 16'd1, 16'd1, 32'h1, 32'h1,
                  acl_pkg::PolicyAccept, 1'b0);
        drain();
        write_cfg(acl_pkg::CfgEnable, 1'b0);
        write_cfg(acl_pkg::CfgInDefault, 1'b1);
        write_cfg(acl_pkg::CfgOutDefault, 1'b1);
        send_item(acl_pkg::ModeClassify, 1'b0, acl_pkg::ProtoTcp, 16'd1, 16'd2, 32'h3,
                  32'h4, acl_pkg::PolicyAccept, 1'b0);
        send_item(acl_pkg::ModeClassify, 1'b1, acl_pkg::ProtoUdp, 16'd1, 16'd2, 32'h3,
                  32'h4, acl_pkg::PolicyAccept, 1'b0);
        drain();
        write_cfg(acl_pkg::CfgEnable, 1'b1);
        // empty both chains by deleting everything plausible is slow; delete output
        // chain entries instead
        for (int i = 0; i < acl_pkg::RulesPerChain; i++)
            send_item(acl_pkg::ModeDelete, 1'b1, acl_pkg::ProtoUdp, i[15:0] + 16'd100,
                      16'd0, 32'h0, 32'h0, acl_pkg::PolicyAccept, 1'b0);
        send_item(acl_pkg::ModeDelete, 1'b1, 8'd1, 16'd0, 16'd0, 32'h0, 32'h0,
                  acl_pkg::PolicyAccept, 1'b0);
        send_item(acl_pkg::ModeDelete, 1'b1, acl_pkg::ProtoTcp, 16'd0, 16'd0, 32'h0, 32'h0,
                  acl_pkg::PolicyAccept, 1'b0);
        drain();

        // random phases with different default settings
        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            write_cfg(acl_pkg::CfgInDefault, ph[0]);
            write_cfg(acl_pkg::CfgOutDefault, ph[1]);
            write_cfg(acl_pkg::CfgEnable, ph != 3 || $urandom_range(0, 1) != 0);
            for (int k = 0; k < 8; k++) begin
                pool_proto[k] = $urandom_range(0, 3) == 0 ? acl_pkg::ProtoTcp :
                                ($urandom_range(0, 2) == 0 ? 8'($urandom) : acl_pkg::ProtoUdp);
                if (k < 4) pool_proto[k] = k[0] ? acl_pkg::ProtoTcp : acl_pkg::ProtoUdp;
                pool_sp[k] = 16'($urandom);
                pool_dp[k] = 16'($urandom);
                pool_sa[k] = $urandom;
                pool_da[k] = $urandom;
            end
            while (sent < (ph + 1) * 175) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst; b++) begin
                    random_item();
                    sent++;
                end
                if ($urandom_range(0, 1) != 0) idle_gap($urandom_range(1, 8));
            end
            drain();
        end
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

/* sim.f */
design/acl_pkg.sv
design/acl_datapath.sv
design/acl_ctrl.sv
design/five_tuple_acl_classifier_top.sv
sim/acl_checker.sv
sim/five_tuple_acl_classifier_top_tb.sv
